// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Depends on clk and rst_n being visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/scfla_pkg.sv =====
// Package for the size class free list allocator: widths, codes, states, helpers.
// No dependencies.
`timescale 1ns / 1ps

package scfla_pkg;

    localparam int NUM_CLASSES     = 16;
    localparam int ALIGN_BYTES     = 8;
    localparam int MAX_SMALL_BYTES = 128;
    localparam int BATCH           = 20;
    localparam int ADDR_W          = 16;

    localparam int SMALL_LIMIT = (MAX_SMALL_BYTES < NUM_CLASSES * ALIGN_BYTES) ?
                                 MAX_SMALL_BYTES : NUM_CLASSES * ALIGN_BYTES;
    localparam int PTR_W    = ADDR_W + 1;
    localparam int ALIGN_SH = $clog2(ALIGN_BYTES);
    localparam int GRAN_W   = ADDR_W - ALIGN_SH;
    localparam int CLS_W    = $clog2(NUM_CLASSES);
    localparam int BYTES_W  = $clog2(SMALL_LIMIT + ALIGN_BYTES + 1);
    localparam int NEED_W   = $clog2(SMALL_LIMIT * BATCH + 1);
    localparam int CNT_W    = $clog2(BATCH + 1);
    localparam int GROW_W   = NEED_W + 2 + PTR_W - 4;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_FREE    = 2'd1;
    localparam logic [1:0] KIND_REALLOC = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_BIG  = 2'd1;
    localparam logic [1:0] STAT_OOM  = 2'd2;
    localparam logic [1:0] STAT_ZERO = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FREE,
        S_ALLOC,
        S_POP,
        S_CARVE,
        S_DIVIDE,
        S_SCAN,
        S_CHAIN,
        S_LINK,
        S_DONE
    } state_t;

    // Size class of a byte count, clamped to the class range
    function automatic logic [CLS_W-1:0] class_of(input logic [PTR_W-1:0] b);
        logic [PTR_W:0] c;
        c = ({1'b0, b} + (PTR_W+1)'(ALIGN_BYTES - 1)) >> ALIGN_SH;
        if (c == '0)
            c = (PTR_W+1)'(1);
        c = c - (PTR_W+1)'(1);
        if (c >= (PTR_W+1)'(NUM_CLASSES))
            c = (PTR_W+1)'(NUM_CLASSES - 1);
        return c[CLS_W-1:0];
    endfunction

    // Link memory index of a byte address
    function automatic logic [GRAN_W-1:0] granule(input logic [PTR_W-1:0] a);
        return a[ADDR_W-1:ALIGN_SH];
    endfunction

endpackage

// ===== rtl/core/size_class_free_list_allocator.sv =====
// Top level of the size class free list allocator: sequencer, class heads, link memory.
// Depends on scfla_pkg and assert_macros.svh.
// A list hit passes S_ALLOC, S_POP, S_DONE; a free S_FREE, S_DONE; a refill adds S_CARVE
// growth steps, one S_DIVIDE count step per block, S_CHAIN and one S_LINK write per chained
// block, a scavenge one S_SCAN step per size class. One word in flight; the next is taken in
// the cycle after the result loads. Reset: heads, pool, heap 0, arena_next 8, limit 65536.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module size_class_free_list_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [15:0] size,
    input  logic [15:0] new_size,
    input  logic [15:0] block_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] granted_address,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] arena_limit
);

    localparam int PW = scfla_pkg::PTR_W;
    localparam int AW = scfla_pkg::ADDR_W;

    // Control state
    scfla_pkg::state_t state_reg, state_next;
    logic [PW-1:0] pool_start_reg, pool_start_next;
    logic [PW-1:0] pool_end_reg, pool_end_next;
    logic [PW-1:0] heap_reg, heap_next;
    logic [PW-1:0] arena_next_reg, arena_next_next;
    logic [PW-1:0] limit_reg;
    logic          out_valid_reg, out_valid_next;
    logic [AW-1:0] heads_reg [scfla_pkg::NUM_CLASSES];

    // Payload and work registers
    logic [1:0]    kind_reg, kind_next;
    logic [15:0]   size_reg, size_next;
    logic [15:0]   nsize_reg, nsize_next;
    logic [15:0]   addr_reg, addr_next;
    logic [15:0]   req_reg, req_next;
    logic [scfla_pkg::BYTES_W-1:0] bytes_reg, bytes_next;
    logic [scfla_pkg::NEED_W-1:0]  need_reg, need_next;
    logic [scfla_pkg::CLS_W-1:0]   cls_reg, cls_next;
    logic [scfla_pkg::CLS_W-1:0]   pop_cls_reg, pop_cls_next;
    logic          pop_scav_reg, pop_scav_next;
    logic [AW-1:0] pop_addr_reg, pop_addr_next;
    logic [scfla_pkg::BYTES_W-1:0] scan_reg, scan_next;
    logic [scfla_pkg::NEED_W-1:0]  acc_reg, acc_next;
    logic [scfla_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [scfla_pkg::CNT_W-1:0]   k_reg, k_next;
    logic [PW-1:0] base_reg, base_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic [AW-1:0] res_addr_reg, res_addr_next;
    logic [1:0]    res_stat_reg, res_stat_next;
    logic [AW-1:0] out_addr_reg, out_addr_next;
    logic [1:0]    out_stat_reg, out_stat_next;

    // Class head access
    logic [scfla_pkg::CLS_W-1:0] head_ridx;
    logic [AW-1:0]               head_rdata;
    logic                        head_we;
    logic [scfla_pkg::CLS_W-1:0] head_widx;
    logic [AW-1:0]               head_wdata;

    // Link memory port
    logic [AW-1:0] link_mem [2**scfla_pkg::GRAN_W];
    logic                         mem_we;
    logic [scfla_pkg::GRAN_W-1:0] mem_addr;
    logic [AW-1:0]                mem_wdata;
    logic [AW-1:0]                mem_rdata_reg;

    // Datapath helpers
    logic [PW-1:0]              left_c;
    logic [scfla_pkg::CLS_W-1:0] req_cls_c;
    logic [scfla_pkg::BYTES_W-1:0] bytes_c;
    logic [scfla_pkg::GROW_W-1:0] grow_c;
    logic [PW:0]                arena_sum_c;
    logic [PW-1:0]              eff_limit_c;
    logic [scfla_pkg::NEED_W:0] acc_sum_c;

    assign head_rdata = heads_reg[head_ridx];
    assign in_ready   = (state_reg == scfla_pkg::S_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign granted_address = out_addr_reg;
    assign status     = out_stat_reg;

    assign left_c = (pool_end_reg >= pool_start_reg) ? (pool_end_reg - pool_start_reg) : '0;
    assign req_cls_c = scfla_pkg::class_of(PW'(req_reg));
    assign bytes_c = scfla_pkg::BYTES_W'(((PW'(req_reg) + PW'(scfla_pkg::ALIGN_BYTES - 1))
                     >> scfla_pkg::ALIGN_SH) << scfla_pkg::ALIGN_SH);
    assign grow_c = scfla_pkg::GROW_W'({need_reg, 1'b0})
                  + scfla_pkg::GROW_W'((((heap_reg >> 4) + PW'(scfla_pkg::ALIGN_BYTES - 1))
                     >> scfla_pkg::ALIGN_SH) << scfla_pkg::ALIGN_SH);
    assign arena_sum_c = {1'b0, arena_next_reg} + (PW+1)'(grow_c);
    assign eff_limit_c = (limit_reg > PW'(2**AW)) ? PW'(2**AW) : limit_reg;
    assign acc_sum_c = {1'b0, acc_reg} + (scfla_pkg::NEED_W+1)'(bytes_reg);

    // Next state and datapath
    always_comb
    begin
        state_next = state_reg;
        pool_start_next = pool_start_reg;
        pool_end_next = pool_end_reg;
        heap_next = heap_reg;
        arena_next_next = arena_next_reg;
        out_valid_next = out_valid_reg;
        kind_next = kind_reg;
        size_next = size_reg;
        nsize_next = nsize_reg;
        addr_next = addr_reg;
        req_next = req_reg;
        bytes_next = bytes_reg;
        need_next = need_reg;
        cls_next = cls_reg;
        pop_cls_next = pop_cls_reg;
        pop_scav_next = pop_scav_reg;
        pop_addr_next = pop_addr_reg;
        scan_next = scan_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        k_next = k_reg;
        base_next = base_reg;
        cur_next = cur_reg;
        res_addr_next = res_addr_reg;
        res_stat_next = res_stat_reg;
        out_addr_next = out_addr_reg;
        out_stat_next = out_stat_reg;
        head_ridx = req_cls_c;
        head_we = 1'b0;
        head_widx = '0;
        head_wdata = '0;
        mem_we = 1'b0;
        mem_addr = '0;
        mem_wdata = '0;

        // Drop the result word once taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            scfla_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = kind;
                    size_next = size;
                    nsize_next = new_size;
                    addr_next = block_address;
                    req_next = size;
                    res_addr_next = '0;
                    res_stat_next = scfla_pkg::STAT_OK;
                    if (kind == scfla_pkg::KIND_ALLOC)
                        state_next = scfla_pkg::S_ALLOC;
                    else if (kind == scfla_pkg::KIND_FREE || kind == scfla_pkg::KIND_REALLOC)
                        state_next = scfla_pkg::S_FREE;
                    else
                        state_next = scfla_pkg::S_DONE;
                end
            end

            scfla_pkg::S_FREE:
            begin
                // Push the freed block on its class list (sizes 1 to 128, non-null address)
                head_ridx = scfla_pkg::class_of(PW'(size_reg));
                if (size_reg == '0)
                    res_stat_next = scfla_pkg::STAT_ZERO;
                else if (size_reg > 16'(scfla_pkg::SMALL_LIMIT))
                    res_stat_next = scfla_pkg::STAT_BIG;
                else
                begin
                    res_stat_next = scfla_pkg::STAT_OK;
                    if (addr_reg != '0)
                    begin
                        mem_we = 1'b1;
                        mem_addr = scfla_pkg::granule(PW'(addr_reg));
                        mem_wdata = head_rdata;
                        head_we = 1'b1;
                        head_widx = head_ridx;
                        head_wdata = addr_reg;
                    end
                end
                if (kind_reg == scfla_pkg::KIND_FREE)
                    state_next = scfla_pkg::S_DONE;
                else
                begin
                    req_next = nsize_reg;
                    state_next = scfla_pkg::S_ALLOC;
                end
            end

            scfla_pkg::S_ALLOC:
            begin
                res_addr_next = '0;
                if (req_reg == '0)
                begin
                    res_stat_next = scfla_pkg::STAT_ZERO;
                    state_next = scfla_pkg::S_DONE;
                end
                else if (req_reg > 16'(scfla_pkg::SMALL_LIMIT))
                begin
                    res_stat_next = scfla_pkg::STAT_BIG;
                    state_next = scfla_pkg::S_DONE;
                end
                else
                begin
                    res_stat_next = scfla_pkg::STAT_OK;
                    cls_next = req_cls_c;
                    if (head_rdata != '0)
                    begin
                        mem_addr = scfla_pkg::granule(PW'(head_rdata));
                        pop_cls_next = req_cls_c;
                        pop_scav_next = 1'b0;
                        pop_addr_next = head_rdata;
                        state_next = scfla_pkg::S_POP;
                    end
                    else
                    begin
                        bytes_next = bytes_c;
                        need_next = scfla_pkg::NEED_W'(bytes_c * scfla_pkg::BATCH);
                        state_next = scfla_pkg::S_CARVE;
                    end
                end
            end

            scfla_pkg::S_POP:
            begin
                // Link word is back: advance the head
                head_we = 1'b1;
                head_widx = pop_cls_reg;
                head_wdata = mem_rdata_reg;
                if (!pop_scav_reg)
                begin
                    res_addr_next = pop_addr_reg;
                    state_next = scfla_pkg::S_DONE;
                end
                else
                begin
                    pool_start_next = PW'(pop_addr_reg);
                    pool_end_next = PW'(pop_addr_reg) + PW'(scan_reg);
                    state_next = scfla_pkg::S_CARVE;
                end
            end

            scfla_pkg::S_CARVE:
            begin
                head_ridx = scfla_pkg::class_of(left_c);
                if (left_c >= PW'(need_reg))
                begin
                    base_next = pool_start_reg;
                    pool_start_next = pool_start_reg + PW'(need_reg);
                    cnt_next = scfla_pkg::CNT_W'(scfla_pkg::BATCH);
                    state_next = scfla_pkg::S_CHAIN;
                end
                else if (left_c >= PW'(bytes_reg))
                begin
                    acc_next = '0;
                    cnt_next = '0;
                    state_next = scfla_pkg::S_DIVIDE;
                end
                else
                begin
                    // Push the leftover, then grow or scavenge
                    if (left_c != '0)
                    begin
                        mem_we = 1'b1;
                        mem_addr = scfla_pkg::granule(pool_start_reg);
                        mem_wdata = head_rdata;
                        head_we = 1'b1;
                        head_widx = head_ridx;
                        head_wdata = pool_start_reg[AW-1:0];
                    end
                    if (arena_sum_c <= {1'b0, eff_limit_c})
                    begin
                        pool_start_next = arena_next_reg;
                        pool_end_next = arena_sum_c[PW-1:0];
                        arena_next_next = arena_sum_c[PW-1:0];
                        heap_next = heap_reg + PW'(grow_c);
                    end
                    else
                    begin
                        scan_next = bytes_reg;
                        state_next = scfla_pkg::S_SCAN;
                    end
                end
            end

            scfla_pkg::S_DIVIDE:
            begin
                // Count whole blocks left in the pool, one per cycle
                if (PW'(acc_sum_c) <= left_c)
                begin
                    acc_next = acc_sum_c[scfla_pkg::NEED_W-1:0];
                    cnt_next = cnt_reg + scfla_pkg::CNT_W'(1);
                end
                else
                begin
                    base_next = pool_start_reg;
                    pool_start_next = pool_start_reg + PW'(acc_reg);
                    state_next = scfla_pkg::S_CHAIN;
                end
            end

            scfla_pkg::S_SCAN:
            begin
                // Look one class per cycle for a block to use as pool
                head_ridx = scfla_pkg::class_of(PW'(scan_reg));
                if (head_rdata != '0)
                begin
                    mem_addr = scfla_pkg::granule(PW'(head_rdata));
                    pop_cls_next = head_ridx;
                    pop_scav_next = 1'b1;
                    pop_addr_next = head_rdata;
                    state_next = scfla_pkg::S_POP;
                end
                else if ((PW'(scan_reg) + PW'(scfla_pkg::ALIGN_BYTES))
                         > PW'(scfla_pkg::SMALL_LIMIT))
                begin
                    pool_start_next = '0;
                    pool_end_next = '0;
                    res_stat_next = scfla_pkg::STAT_OOM;
                    res_addr_next = '0;
                    state_next = scfla_pkg::S_DONE;
                end
                else
                    scan_next = scan_reg + scfla_pkg::BYTES_W'(scfla_pkg::ALIGN_BYTES);
            end

            scfla_pkg::S_CHAIN:
            begin
                res_addr_next = base_reg[AW-1:0];
                if (cnt_reg > scfla_pkg::CNT_W'(1))
                begin
                    head_we = 1'b1;
                    head_widx = cls_reg;
                    head_wdata = AW'(base_reg + PW'(bytes_reg));
                    cur_next = base_reg + PW'(bytes_reg);
                    k_next = scfla_pkg::CNT_W'(1);
                    state_next = scfla_pkg::S_LINK;
                end
                else
                    state_next = scfla_pkg::S_DONE;
            end

            scfla_pkg::S_LINK:
            begin
                // Chain spare blocks, one link write per cycle
                mem_we = 1'b1;
                mem_addr = scfla_pkg::granule(cur_reg);
                mem_wdata = (k_reg == cnt_reg - scfla_pkg::CNT_W'(1)) ?
                            '0 : AW'(cur_reg + PW'(bytes_reg));
                cur_next = cur_reg + PW'(bytes_reg);
                k_next = k_reg + scfla_pkg::CNT_W'(1);
                if (k_reg == cnt_reg - scfla_pkg::CNT_W'(1))
                    state_next = scfla_pkg::S_DONE;
            end

            scfla_pkg::S_DONE:
            begin
                // Hand the word over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next = res_addr_reg;
                    out_stat_next = res_stat_reg;
                    state_next = scfla_pkg::S_IDLE;
                end
            end

            default:
                state_next = scfla_pkg::S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scfla_pkg::S_IDLE;
            pool_start_reg <= '0;
            pool_end_reg <= '0;
            heap_reg <= '0;
            arena_next_reg <= PW'(scfla_pkg::ALIGN_BYTES);
            limit_reg <= PW'(2**AW);
            out_valid_reg <= 1'b0;
            for (int i = 0; i < scfla_pkg::NUM_CLASSES; i++)
                heads_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pool_start_reg <= pool_start_next;
            pool_end_reg <= pool_end_next;
            heap_reg <= heap_next;
            arena_next_reg <= arena_next_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                limit_reg <= arena_limit;
            if (head_we)
                heads_reg[head_widx] <= head_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        size_reg <= size_next;
        nsize_reg <= nsize_next;
        addr_reg <= addr_next;
        req_reg <= req_next;
        bytes_reg <= bytes_next;
        need_reg <= need_next;
        cls_reg <= cls_next;
        pop_cls_reg <= pop_cls_next;
        pop_scav_reg <= pop_scav_next;
        pop_addr_reg <= pop_addr_next;
        scan_reg <= scan_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
        k_reg <= k_next;
        base_reg <= base_next;
        cur_reg <= cur_next;
        res_addr_reg <= res_addr_next;
        res_stat_reg <= res_stat_next;
        out_addr_reg <= out_addr_next;
        out_stat_reg <= out_stat_next;
    end

    // Link memory, one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            link_mem[mem_addr] <= mem_wdata;
        mem_rdata_reg <= link_mem[mem_addr];
    end

    `ASSERT_NEXT(a_out_hold, out_valid_reg && !out_ready, out_valid_reg)
    `ASSERT_IMPLY(a_oom_null, out_valid_reg && out_stat_reg == scfla_pkg::STAT_OOM,
        out_addr_reg == '0)
    `ASSERT_IMPLY(a_link_count, state_reg == scfla_pkg::S_LINK,
        k_reg < cnt_reg && cnt_reg <= scfla_pkg::CNT_W'(scfla_pkg::BATCH))

endmodule

// ===== sim/size_class_free_list_allocator_tb.sv =====
// Testbench for the size class free list allocator: bursty sender, stalling receiver,
// in-bench prediction of class lists, pool carving, arena growth and scavenging.
// Depends on scfla_pkg and size_class_free_list_allocator.
`timescale 1ns / 1ps

module size_class_free_list_allocator_tb;

    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 120;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] size;
        logic [15:0] new_size;
        logic [15:0] block_address;
    } request_t;

    typedef struct {
        logic [15:0] granted_address;
        logic [1:0]  status;
    } grant_t;

    typedef struct {
        logic [15:0] addr;
        logic [15:0] size;
    } live_block_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  kind = '0;
    logic [15:0] size = '0;
    logic [15:0] new_size = '0;
    logic [15:0] block_address = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] granted_address;
    logic [1:0]  status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [16:0] arena_limit = 17'd65536;

    request_t    pending_requests[$];
    grant_t      expected_grants[$];
    live_block_t live_blocks[$];
    int          errors = 0;
    int          accepted_count = 0;
    int          cycle_count = 0;

    // Predicted allocator state
    logic [15:0] head_of[scfla_pkg::NUM_CLASSES];
    logic [15:0] next_link[8192];
    longint      pool_lo, pool_hi, heap_bytes, arena_top, arena_cap;

    size_class_free_list_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .size(size), .new_size(new_size), .block_address(block_address),
        .out_valid(out_valid), .out_ready(out_ready),
        .granted_address(granted_address), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .arena_limit(arena_limit)
    );

    always #5 clk = ~clk;

    function automatic int size_class(input longint b);
        longint c;
        c = (b + scfla_pkg::ALIGN_BYTES - 1) / scfla_pkg::ALIGN_BYTES;
        if (c == 0)
            c = 1;
        c = c - 1;
        if (c >= scfla_pkg::NUM_CLASSES)
            c = scfla_pkg::NUM_CLASSES - 1;
        return int'(c);
    endfunction

    function automatic int link_slot(input longint a);
        return int'((a & 64'hFFFF) / scfla_pkg::ALIGN_BYTES);
    endfunction

    function automatic void push_free(input int cls, input longint a);
        next_link[link_slot(a)] = head_of[cls];
        head_of[cls] = a[15:0];
    endfunction

    function automatic logic [15:0] pop_free(input int cls);
        logic [15:0] a;
        a = head_of[cls];
        head_of[cls] = next_link[link_slot(a)];
        return a;
    endfunction

    // Take up to count blocks from the pool, growing or scavenging it as needed
    function automatic bit carve_pool(input longint bytes, inout longint count,
                                      output longint base);
        longint need, left, grow, cap, i;
        bit     found;
        base = 0;
        while (1)
        begin
            need = bytes * count;
            left = (pool_hi >= pool_lo) ? pool_hi - pool_lo : 0;
            found = 1'b0;
            if (left >= need)
            begin
                base = pool_lo;
                pool_lo += need;
                return 1'b1;
            end
            if (left >= bytes)
            begin
                count = left / bytes;
                base = pool_lo;
                pool_lo += count * bytes;
                return 1'b1;
            end
            grow = 2 * need + (((heap_bytes >> 4) + scfla_pkg::ALIGN_BYTES - 1)
                   / scfla_pkg::ALIGN_BYTES) * scfla_pkg::ALIGN_BYTES;
            if (left > 0)
                push_free(size_class(left), pool_lo);
            cap = (arena_cap < 65536) ? arena_cap : 65536;
            if (arena_top + grow <= cap)
            begin
                pool_lo = arena_top;
                pool_hi = arena_top + grow;
                arena_top += grow;
                heap_bytes += grow;
                continue;
            end
            for (i = bytes; i <= scfla_pkg::SMALL_LIMIT; i += scfla_pkg::ALIGN_BYTES)
            begin
                if (head_of[size_class(i)] != 0)
                begin
                    pool_lo = pop_free(size_class(i));
                    pool_hi = pool_lo + i;
                    found = 1'b1;
                    break;
                end
            end
            if (!found)
            begin
                pool_lo = 0;
                pool_hi = 0;
                return 1'b0;
            end
        end
    endfunction

    function automatic grant_t allocate(input longint req);
        grant_t g;
        longint bytes, count, base, k, cur;
        int     cls;
        g.granted_address = '0;
        g.status = scfla_pkg::STAT_OK;
        if (req == 0)
        begin
            g.status = scfla_pkg::STAT_ZERO;
            return g;
        end
        if (req > scfla_pkg::SMALL_LIMIT)
        begin
            g.status = scfla_pkg::STAT_BIG;
            return g;
        end
        cls = size_class(req);
        if (head_of[cls] != 0)
        begin
            g.granted_address = pop_free(cls);
            return g;
        end
        bytes = ((req + scfla_pkg::ALIGN_BYTES - 1) / scfla_pkg::ALIGN_BYTES)
                * scfla_pkg::ALIGN_BYTES;
        count = scfla_pkg::BATCH;
        if (!carve_pool(bytes, count, base))
        begin
            g.status = scfla_pkg::STAT_OOM;
            return g;
        end
        // Chain the spare blocks into the class list
        if (count > 1)
        begin
            head_of[cls] = 16'((base + bytes) & 64'hFFFF);
            for (k = 1; k < count; k++)
            begin
                cur = base + k * bytes;
                next_link[link_slot(cur)] = (k == count - 1) ? 16'd0
                                            : 16'((cur + bytes) & 64'hFFFF);
            end
        end
        g.granted_address = base[15:0];
        return g;
    endfunction

    function automatic logic [1:0] release_block(input longint a, input longint sz);
        if (sz == 0)
            return scfla_pkg::STAT_ZERO;
        if (sz > scfla_pkg::SMALL_LIMIT)
            return scfla_pkg::STAT_BIG;
        if (a != 0)
            push_free(size_class(sz), a);
        return scfla_pkg::STAT_OK;
    endfunction

    function automatic grant_t predict_grant(input request_t r);
        grant_t g;
        live_block_t lb;
        g.granted_address = '0;
        g.status = scfla_pkg::STAT_OK;
        case (r.kind)
            scfla_pkg::KIND_ALLOC: g = allocate(r.size);
            scfla_pkg::KIND_FREE: g.status = release_block(r.block_address, r.size);
            scfla_pkg::KIND_REALLOC:
            begin
                void'(release_block(r.block_address, r.size));
                g = allocate(r.new_size);
            end
            default: ;
        endcase
        // Remember served blocks so later frees hit real ones
        if ((r.kind == scfla_pkg::KIND_ALLOC || r.kind == scfla_pkg::KIND_REALLOC)
            && g.status == scfla_pkg::STAT_OK && g.granted_address != 0)
        begin
            lb.addr = g.granted_address;
            lb.size = (r.kind == scfla_pkg::KIND_ALLOC) ? r.size : r.new_size;
            live_blocks.push_back(lb);
        end
        return g;
    endfunction

    // Driver: bursts with random gaps, predict on every accepted word
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        request_t r;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                arena_cap = arena_limit;
            if (in_valid && in_ready)
            begin
                r.kind = kind;
                r.size = size;
                r.new_size = new_size;
                r.block_address = block_address;
                expected_grants.push_back(predict_grant(r));
                accepted_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    r = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    kind <= r.kind;
                    size <= r.size;
                    new_size <= r.new_size;
                    block_address <= r.block_address;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, quiet stretches, and one long hold-off
    int hold_left = 0;
    int stall_mode = 0;
    bit long_hold_done = 1'b0;
    always @(posedge clk)
    begin
        if (!long_hold_done && accepted_count >= 300)
        begin
            long_hold_done = 1'b1;
            hold_left = 500;
        end
        if ($urandom_range(0, 99) == 0)
            stall_mode = $urandom_range(0, 2);
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_mode == 0)
            out_ready <= 1'b1;
        else if (stall_mode == 1)
            out_ready <= ($urandom_range(0, 3) != 0);
        else
            out_ready <= ($urandom_range(0, 3) == 0);
    end

    // Monitor: compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        grant_t g;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_grants.size() == 0)
            begin
                $error("unexpected result word: granted_address %0h status %0d",
                       granted_address, status);
                errors++;
            end
            else
            begin
                g = expected_grants.pop_front();
                if (granted_address !== g.granted_address)
                begin
                    $error("granted_address expected %0h actual %0h",
                           g.granted_address, granted_address);
                    errors++;
                end
                if (status !== g.status)
                begin
                    $error("status expected %0d actual %0d", g.status, status);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic queue_request(input logic [1:0] k, input logic [15:0] s,
                                 input logic [15:0] ns, input logic [15:0] a);
        request_t r;
        r.kind = k;
        r.size = s;
        r.new_size = ns;
        r.block_address = a;
        pending_requests.push_back(r);
    endtask

    function automatic logic [15:0] pick_size();
        int p;
        p = $urandom_range(0, 99);
        if (p < 85)
            return 16'($urandom_range(1, scfla_pkg::SMALL_LIMIT));
        if (p < 92)
            return 16'($urandom_range(scfla_pkg::SMALL_LIMIT + 1, 65535));
        if (p < 96)
            return 16'd0;
        return 16'($urandom);
    endfunction

    task automatic queue_random_request();
        live_block_t lb;
        int p, idx;
        p = $urandom_range(0, 99);
        if (p >= 45 && p < 90 && live_blocks.size() > 0)
        begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            lb = live_blocks[idx];
            live_blocks.delete(idx);
            if (p < 78)
                queue_request(scfla_pkg::KIND_FREE, lb.size, 16'($urandom), lb.addr);
            else
                queue_request(scfla_pkg::KIND_REALLOC, lb.size, pick_size(), lb.addr);
        end
        else if (p < 92)
            queue_request(scfla_pkg::KIND_ALLOC, pick_size(), 16'($urandom), 16'($urandom));
        else
            queue_request(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic wait_idle();
        while (pending_requests.size() > 0 || expected_grants.size() > 0 || in_valid)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_arena_limit(input logic [16:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        arena_limit <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    logic [16:0] phase_limits[5] = '{17'd65536, 17'd131071, 17'd3000, 17'd0, 17'd65536};

    initial
    begin
        int ph, n;
        for (int c = 0; c < scfla_pkg::NUM_CLASSES; c++)
            head_of[c] = '0;
        pool_lo = 0;
        pool_hi = 0;
        heap_bytes = 0;
        arena_top = 8;
        arena_cap = 65536;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: size edges, every operation, ignored frees, unknown kind
        queue_request(scfla_pkg::KIND_ALLOC, 16'd0, 16'd0, 16'd0);
        queue_request(scfla_pkg::KIND_ALLOC, 16'd1, 16'd0, 16'd0);
        queue_request(scfla_pkg::KIND_ALLOC, 16'd8, 16'd0, 16'd0);
        queue_request(scfla_pkg::KIND_ALLOC, 16'd9, 16'd0, 16'd0);
        queue_request(scfla_pkg::KIND_ALLOC, 16'(scfla_pkg::SMALL_LIMIT), 16'd0, 16'd0);
        queue_request(scfla_pkg::KIND_ALLOC, 16'(scfla_pkg::SMALL_LIMIT + 1), 16'd0, 16'd0);
        queue_request(scfla_pkg::KIND_ALLOC, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_request(scfla_pkg::KIND_FREE, 16'd0, 16'd0, 16'd64);
        queue_request(scfla_pkg::KIND_FREE, 16'd200, 16'd0, 16'd64);
        queue_request(scfla_pkg::KIND_FREE, 16'd16, 16'd0, 16'd0);
        queue_request(scfla_pkg::KIND_FREE, 16'd8, 16'd0, 16'd8);
        queue_request(scfla_pkg::KIND_ALLOC, 16'd8, 16'd0, 16'd0);
        queue_request(scfla_pkg::KIND_REALLOC, 16'd8, 16'd24, 16'd8);
        queue_request(scfla_pkg::KIND_REALLOC, 16'd24, 16'd0, 16'd0);
        queue_request(scfla_pkg::KIND_REALLOC, 16'd0, 16'd300, 16'd0);
        queue_request(KIND_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_request(scfla_pkg::KIND_FREE, 16'd120, 16'd0, 16'hFFF8);
        queue_request(scfla_pkg::KIND_ALLOC, 16'd120, 16'd0, 16'd0);

        for (ph = 0; ph < 5; ph++)
        begin
            if (ph > 0)
            begin
                wait_idle();
                write_arena_limit(phase_limits[ph]);
            end
            n = 0;
            while (n < 220)
            begin
                @(posedge clk);
                while (pending_requests.size() < 4 && n < 220)
                begin
                    queue_random_request();
                    n++;
                end
            end
        end

        wait_idle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/scfla_pkg.sv
rtl/core/size_class_free_list_allocator.sv
sim/size_class_free_list_allocator_tb.sv
